// ===== sv/mailbox_register_pair_defines.svh =====
// Assertion macros shared by the mailbox register pair RTL.
`ifndef MAILBOX_REGISTER_PAIR_DEFINES_SVH
`define MAILBOX_REGISTER_PAIR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MBRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mailbox register pair: implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mailbox register pair: next-cycle check failed");

`else

`define MBRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MBRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mbrp_pkg.sv =====
// Types, register offsets and identity constants for the mailbox register pair.
package mbrp_pkg;

	localparam int OffW  = 12;
	localparam int WordW = 32;

	// Access kind and window codes.
	localparam logic KindRead      = 1'b0;
	localparam logic KindWrite     = 1'b1;
	localparam logic WinReceiver   = 1'b0;
	localparam logic WinSender     = 1'b1;

	// Register offsets within a window.
	localparam logic [OffW-1:0] OffChSt     = 12'h000;
	localparam logic [OffW-1:0] OffChStMsk  = 12'h004;
	localparam logic [OffW-1:0] OffChClr    = 12'h008;
	localparam logic [OffW-1:0] OffChSet    = 12'h00C;
	localparam logic [OffW-1:0] OffChIntSt  = 12'h010;
	localparam logic [OffW-1:0] OffChIntClr = 12'h014;
	localparam logic [OffW-1:0] OffChIntEn  = 12'h018;
	localparam logic [OffW-1:0] OffMhuCfg   = 12'hF80;
	localparam logic [OffW-1:0] OffRespCfg  = 12'hF84;
	localparam logic [OffW-1:0] OffAccReq   = 12'hF88;
	localparam logic [OffW-1:0] OffAccRdy   = 12'hF8C;
	localparam logic [OffW-1:0] OffIntSt    = 12'hF90;
	localparam logic [OffW-1:0] OffIntEn    = 12'hF98;
	localparam logic [OffW-1:0] OffChIntSt0 = 12'hFA0;
	localparam logic [OffW-1:0] OffIidr     = 12'hFC8;
	localparam logic [OffW-1:0] OffAidr     = 12'hFCC;

	// Identity and fixed read values.
	localparam logic [WordW-1:0] IdIidr    = 32'h0760_043B;
	localparam logic [WordW-1:0] IdAidr    = 32'h0000_0011;
	localparam logic [WordW-1:0] CombWord  = 32'h0000_0004;
	localparam logic [WordW-1:0] OneChan   = 32'h0000_0001;
	localparam int               CombBit   = 2;

	localparam int InDataW  = 48;
	localparam int InUserW  = 2;
	localparam int OutDataW = 72;

	// Input item payload, last field in the lowest bits.
	typedef struct packed {
		logic [WordW-1:0] write_data;
		logic [OffW-1:0]  reg_offset;
	} in_data_t;

	typedef struct packed {
		logic window;
		logic kind;
	} in_user_t;

	// Result item, last field in the lowest bits.
	typedef struct packed {
		logic [WordW-1:0] request_word;
		logic             request_valid;
		logic             receiver_irq;
		logic             sender_irq;
		logic [WordW-1:0] read_data;
	} result_t;

	localparam int ResultW = $bits(result_t);

endpackage

// ===== sv/mailbox_register_pair.sv =====
// Mailbox register pair: one-channel sender and receiver register windows.
//
// Each input item is one 32-bit register access to the sender or receiver
// window, and each gives exactly one result item holding the read data, the
// two interrupt line levels after the access and, for a write to the sender
// channel set register, the request word for the service engine. An accepted
// item sits in an input register while decode and the register updates run,
// then moves to the result register. A new item is taken every cycle as long
// as the result register drains; the rate is set only by the result register
// draining to the master side.
`include "mailbox_register_pair_defines.svh"

module mailbox_register_pair
	import mbrp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,  // reg_offset[11:0], write_data[43:12], zero pad
	input  logic [InUserW-1:0]  s_axis_tuser,  // kind[0], window[1]
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata   // read_data[31:0], sender_irq[32],
	                                           // receiver_irq[33], request_valid[34],
	                                           // request_word[66:35], zero pad
);

	in_data_t          data_s1;
	in_user_t          user_s1;
	logic              valid_s1;
	result_t           result_q;
	logic              out_valid_q;
	logic              advance;

	logic [WordW-1:0]  resp_cfg_q, resp_cfg_d;
	logic              acc_req_q, acc_req_d;
	logic [2:0]        snd_int_en_q, snd_int_en_d;
	logic              snd_ch_int_st_q, snd_ch_int_st_d;
	logic              snd_ch_int_en_q, snd_ch_int_en_d;
	logic [2:0]        rcv_int_en_q, rcv_int_en_d;
	logic [WordW-1:0]  rcv_ch_st_q, rcv_ch_st_d;
	logic [WordW-1:0]  rdata;
	logic              req_valid;
	logic [WordW-1:0]  req_word;
	logic              rcv_busy;
	result_t           result_d;

	// The result register frees up whenever it is empty or being taken.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OutDataW-ResultW){1'b0}}, result_q};

	assign rcv_busy = (rcv_ch_st_q != '0);

	always_comb begin
		resp_cfg_d      = resp_cfg_q;
		acc_req_d       = acc_req_q;
		snd_int_en_d    = snd_int_en_q;
		snd_ch_int_st_d = snd_ch_int_st_q;
		snd_ch_int_en_d = snd_ch_int_en_q;
		rcv_int_en_d    = rcv_int_en_q;
		rcv_ch_st_d     = rcv_ch_st_q;
		rdata           = '0;
		req_valid       = 1'b0;
		req_word        = '0;
		if (user_s1.kind == KindRead) begin
			if (user_s1.window == WinSender) begin
				case (data_s1.reg_offset)
					OffChIntSt:  rdata = {{(WordW-1){1'b0}}, snd_ch_int_st_q};
					OffChIntEn:  rdata = {{(WordW-1){1'b0}}, snd_ch_int_en_q};
					OffMhuCfg:   rdata = OneChan;
					OffRespCfg:  rdata = resp_cfg_q;
					OffAccReq:   rdata = {{(WordW-1){1'b0}}, acc_req_q};
					OffAccRdy:   rdata = {{(WordW-1){1'b0}}, acc_req_q};
					OffIntSt:    rdata = snd_ch_int_st_q ? CombWord : '0;
					OffIntEn:    rdata = {{(WordW-3){1'b0}}, snd_int_en_q};
					OffChIntSt0: rdata = {{(WordW-1){1'b0}}, snd_ch_int_st_q};
					OffIidr:     rdata = IdIidr;
					OffAidr:     rdata = IdAidr;
					default:     rdata = '0;
				endcase
			end else begin
				case (data_s1.reg_offset)
					OffChSt:     rdata = rcv_ch_st_q;
					OffChStMsk:  rdata = rcv_ch_st_q;
					OffMhuCfg:   rdata = OneChan;
					OffIntSt:    rdata = rcv_busy ? CombWord : '0;
					OffIntEn:    rdata = {{(WordW-3){1'b0}}, rcv_int_en_q};
					OffChIntSt0: rdata = {{(WordW-1){1'b0}}, rcv_busy};
					OffIidr:     rdata = IdIidr;
					OffAidr:     rdata = IdAidr;
					default:     rdata = '0;
				endcase
			end
		end else if (user_s1.window == WinSender) begin
			case (data_s1.reg_offset)
				OffChSet: begin
					// The message is consumed at once; a zero word still marks the channel busy.
					if (snd_ch_int_en_q) begin
						snd_ch_int_st_d = 1'b1;
					end
					rcv_ch_st_d = (data_s1.write_data != '0) ? data_s1.write_data : OneChan;
					req_valid   = 1'b1;
					req_word    = data_s1.write_data;
				end
				OffChIntClr: begin
					if (data_s1.write_data[0]) begin
						snd_ch_int_st_d = 1'b0;
					end
				end
				OffChIntEn:  snd_ch_int_en_d = data_s1.write_data[0];
				OffRespCfg:  resp_cfg_d      = data_s1.write_data;
				OffAccReq:   acc_req_d       = data_s1.write_data[0];
				OffIntEn:    snd_int_en_d    = data_s1.write_data[2:0];
				default: begin
				end
			endcase
		end else begin
			case (data_s1.reg_offset)
				OffChClr:    rcv_ch_st_d  = rcv_ch_st_q & ~data_s1.write_data;
				OffIntEn:    rcv_int_en_d = data_s1.write_data[2:0];
				default: begin
				end
			endcase
		end
		result_d.read_data     = rdata;
		result_d.sender_irq    = snd_int_en_d[CombBit] & snd_ch_int_st_d;
		result_d.receiver_irq  = rcv_int_en_d[CombBit] & (rcv_ch_st_d != '0);
		result_d.request_valid = req_valid;
		result_d.request_word  = req_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			resp_cfg_q      <= '0;
			acc_req_q       <= 1'b0;
			snd_int_en_q    <= '0;
			snd_ch_int_st_q <= 1'b0;
			snd_ch_int_en_q <= 1'b0;
			rcv_int_en_q    <= '0;
			rcv_ch_st_q     <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q     <= 1'b1;
				resp_cfg_q      <= resp_cfg_d;
				acc_req_q       <= acc_req_d;
				snd_int_en_q    <= snd_int_en_d;
				snd_ch_int_st_q <= snd_ch_int_st_d;
				snd_ch_int_en_q <= snd_ch_int_en_d;
				rcv_int_en_q    <= rcv_int_en_d;
				rcv_ch_st_q     <= rcv_ch_st_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= in_data_t'(s_axis_tdata[$bits(in_data_t)-1:0]);
			user_s1 <= in_user_t'(s_axis_tuser);
		end
		if (advance) begin
			result_q <= result_d;
		end
	end

	`MBRP_ASSERT_NEXT(a_stalled_item_kept, clk, arst_n, valid_s1 && !advance, valid_s1)
	`MBRP_ASSERT_NEXT(a_chset_marks_busy, clk, arst_n,
		advance && result_d.request_valid, rcv_ch_st_q != '0)
	`MBRP_ASSERT_IMPLY(a_no_stray_request, clk, arst_n,
		out_valid_q && !result_q.request_valid, result_q.request_word == '0)

endmodule

// ===== sim/mailbox_access_checker.sv =====
// Checker for the mailbox register pair: predicts every result item and compares it.
`timescale 1ns / 100ps

module mailbox_access_checker
	import mbrp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,
	input  logic [InUserW-1:0]  s_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic [OutDataW-1:0] m_axis_tdata,
	output int                  fail_count,
	output int                  outstanding,
	output int                  accesses_seen,
	output int                  requests_seen,
	output int                  sender_irq_seen,
	output int                  receiver_irq_seen
);

	// Predicted register state of both windows.
	logic [WordW-1:0] resp_cfg;
	logic             acc_req;
	logic [2:0]       snd_int_en;
	logic             snd_chan_irq_st;
	logic             snd_chan_irq_en;
	logic [2:0]       rcv_int_en;
	logic [WordW-1:0] rcv_status;

	result_t expected_results[$];

	task automatic apply_register_access(input in_user_t u, input in_data_t d,
			output result_t r);
		logic [WordW-1:0] v;
		v = d.write_data;
		r = '0;
		if (u.kind == KindRead) begin
			if (u.window == WinSender) begin
				case (d.reg_offset)
					OffChIntSt:  r.read_data = {31'b0, snd_chan_irq_st};
					OffChIntEn:  r.read_data = {31'b0, snd_chan_irq_en};
					OffMhuCfg:   r.read_data = OneChan;
					OffRespCfg:  r.read_data = resp_cfg;
					OffAccReq:   r.read_data = {31'b0, acc_req};
					OffAccRdy:   r.read_data = {31'b0, acc_req};
					OffIntSt:    r.read_data = snd_chan_irq_st ? CombWord : '0;
					OffIntEn:    r.read_data = {29'b0, snd_int_en};
					OffChIntSt0: r.read_data = {31'b0, snd_chan_irq_st};
					OffIidr:     r.read_data = IdIidr;
					OffAidr:     r.read_data = IdAidr;
					default:     r.read_data = '0;
				endcase
			end else begin
				case (d.reg_offset)
					OffChSt, OffChStMsk: r.read_data = rcv_status;
					OffMhuCfg:   r.read_data = OneChan;
					OffIntSt:    r.read_data = (rcv_status != 0) ? CombWord : '0;
					OffIntEn:    r.read_data = {29'b0, rcv_int_en};
					OffChIntSt0: r.read_data = {31'b0, rcv_status != 0};
					OffIidr:     r.read_data = IdIidr;
					OffAidr:     r.read_data = IdAidr;
					default:     r.read_data = '0;
				endcase
			end
		end else if (u.window == WinSender) begin
			case (d.reg_offset)
				OffChSet: begin
					// The message is consumed at once and forwarded as a request.
					if (snd_chan_irq_en)
						snd_chan_irq_st = 1'b1;
					rcv_status = (v != 0) ? v : 32'd1;
					r.request_valid = 1'b1;
					r.request_word = v;
				end
				OffChIntClr: begin
					if (v[0])
						snd_chan_irq_st = 1'b0;
				end
				OffChIntEn: snd_chan_irq_en = v[0];
				OffRespCfg: resp_cfg = v;
				OffAccReq:  acc_req = v[0];
				OffIntEn:   snd_int_en = v[2:0];
				default: ;
			endcase
		end else begin
			case (d.reg_offset)
				OffChClr: rcv_status = rcv_status & ~v;
				OffIntEn: rcv_int_en = v[2:0];
				default: ;
			endcase
		end
		r.sender_irq = snd_int_en[CombBit] & snd_chan_irq_st;
		r.receiver_irq = rcv_int_en[CombBit] & (rcv_status != 0);
	endtask

	task automatic check_field(input string name, input logic [WordW-1:0] want,
			input logic [WordW-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t pred;
		result_t want;
		result_t got;
		if (!arst_n) begin
			resp_cfg = '0;
			acc_req = 1'b0;
			snd_int_en = '0;
			snd_chan_irq_st = 1'b0;
			snd_chan_irq_en = 1'b0;
			rcv_int_en = '0;
			rcv_status = '0;
			expected_results.delete();
			fail_count = 0;
			outstanding = 0;
			accesses_seen = 0;
			requests_seen = 0;
			sender_irq_seen = 0;
			receiver_irq_seen = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				apply_register_access(in_user_t'(s_axis_tuser),
					in_data_t'(s_axis_tdata[$bits(in_data_t)-1:0]), pred);
				expected_results.push_back(pred);
				accesses_seen++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[ResultW-1:0]);
				if (expected_results.size() == 0) begin
					$error("result item arrived with no access waiting for it");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, got.read_data);
					check_field("sender_irq", WordW'(want.sender_irq),
						WordW'(got.sender_irq));
					check_field("receiver_irq", WordW'(want.receiver_irq),
						WordW'(got.receiver_irq));
					check_field("request_valid", WordW'(want.request_valid),
						WordW'(got.request_valid));
					check_field("request_word", want.request_word, got.request_word);
					requests_seen += int'(got.request_valid);
					sender_irq_seen += int'(got.sender_irq);
					receiver_irq_seen += int'(got.receiver_irq);
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== sim/tb_mailbox_register_pair.sv =====
// Testbench top for the mailbox register pair: register access stimulus and verdict.
`timescale 1ns / 100ps

module tb_mailbox_register_pair;
	import mbrp_pkg::*;

	localparam int RandomAccesses = 1450;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;  // reg_offset[11:0], write_data[43:12], zero pad
	logic [InUserW-1:0]  s_axis_tuser = '0;  // kind[0], window[1]
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;      // read_data[31:0], sender_irq[32],
	                                        // receiver_irq[33], request_valid[34],
	                                        // request_word[66:35], zero pad

	int  fail_count;
	int  outstanding;
	int  accesses_seen;
	int  requests_seen;
	int  sender_irq_seen;
	int  receiver_irq_seen;
	int  directed_count = 0;
	bit  calm = 1'b0;

	localparam logic [OffW-1:0] KnownOffsets [16] = '{
		OffChSt, OffChStMsk, OffChClr, OffChSet, OffChIntSt, OffChIntClr, OffChIntEn,
		OffMhuCfg, OffRespCfg, OffAccReq, OffAccRdy, OffIntSt, OffIntEn, OffChIntSt0,
		OffIidr, OffAidr
	};

	mailbox_register_pair u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	mailbox_access_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.s_axis_tuser      (s_axis_tuser),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.fail_count        (fail_count),
		.outstanding       (outstanding),
		.accesses_seen     (accesses_seen),
		.requests_seen     (requests_seen),
		.sender_irq_seen   (sender_irq_seen),
		.receiver_irq_seen (receiver_irq_seen)
	);

	always #2 clk = ~clk;

	// The result side stalls at random except during the calm stretch.
	always @(negedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 28);
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_access(input logic kind, input logic window,
			input logic [OffW-1:0] offset, input logic [WordW-1:0] data);
		in_data_t d;
		in_user_t u;
		d.reg_offset = offset;
		d.write_data = data;
		u.kind = kind;
		u.window = window;
		// Each idle cycle is drawn on its own, at a chance of 28 in 100 outside the calm stretch.
		while (!calm && $urandom_range(0, 99) < 28) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(InDataW - $bits(in_data_t)){1'b0}}, d};
		s_axis_tuser <= u;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [WordW-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'd1 << $urandom_range(0, 31);
			3: return $urandom_range(0, 7);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [OffW-1:0] pick_offset();
		if ($urandom_range(0, 99) < 85)
			return KnownOffsets[4'($urandom_range(0, 15))];
		return OffW'($urandom_range(0, 4095));
	endfunction

	initial begin
		#2_000_000;
		$display("** mailbox_register_pair: FAILED **");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: identity, enables, zero and full channel set, clears.
		send_access(KindRead,  WinSender,   OffIidr,     '0);
		send_access(KindRead,  WinReceiver, OffAidr,     '0);
		send_access(KindRead,  WinSender,   OffMhuCfg,   '0);
		send_access(KindWrite, WinSender,   OffIntEn,    32'hFFFF_FFFF);
		send_access(KindWrite, WinReceiver, OffIntEn,    32'hFFFF_FFFF);
		send_access(KindWrite, WinSender,   OffChIntEn,  32'h0000_0001);
		// A channel set of zero still marks the receiver status as one.
		send_access(KindWrite, WinSender,   OffChSet,    32'h0000_0000);
		send_access(KindRead,  WinReceiver, OffChSt,     '0);
		send_access(KindRead,  WinReceiver, OffIntSt,    '0);
		send_access(KindRead,  WinSender,   OffChIntSt0, '0);
		send_access(KindWrite, WinSender,   OffChSet,    32'hFFFF_FFFF);
		send_access(KindWrite, WinReceiver, OffChClr,    32'hFFFF_0000);
		send_access(KindRead,  WinReceiver, OffChStMsk,  '0);
		send_access(KindWrite, WinReceiver, OffChClr,    32'hFFFF_FFFF);
		send_access(KindRead,  WinReceiver, OffChIntSt0, '0);
		send_access(KindWrite, WinSender,   OffChIntClr, 32'h0000_0001);
		send_access(KindRead,  WinSender,   OffIntSt,    '0);
		send_access(KindWrite, WinSender,   OffRespCfg,  32'hFFFF_FFFF);
		send_access(KindRead,  WinSender,   OffRespCfg,  '0);
		send_access(KindWrite, WinSender,   OffAccReq,   32'hFFFF_FFFF);
		send_access(KindRead,  WinSender,   OffAccRdy,   '0);
		// Unaligned and unknown offsets.
		send_access(KindRead,  WinSender,   12'hF81,     '0);
		send_access(KindWrite, WinSender,   12'hF94,     32'hFFFF_FFFF);
		send_access(KindRead,  WinReceiver, 12'hFFF,     '0);
		send_access(KindRead,  WinSender,   OffChSt,     '0);
		directed_count = 25;

		for (int i = 0; i < RandomAccesses; i++) begin
			calm = (i >= 600 && i < 850);
			send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_offset(),
				pick_word());
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		wait (outstanding == 0);
		repeat (8) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected result items never arrived", outstanding);
		$display("Covered %0d register accesses (%0d directed) on both windows,",
			accesses_seen, directed_count);
		$display("with %0d channel set requests, sender line high %0d and receiver line high %0d.",
			requests_seen, sender_irq_seen, receiver_irq_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("** mailbox_register_pair: PASSED **");
		else
			$display("** mailbox_register_pair: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/mbrp_pkg.sv
sv/mailbox_register_pair.sv
sim/mailbox_access_checker.sv
sim/tb_mailbox_register_pair.sv
